// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VFQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VFQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vfq_pkg.sv =====
// Types and constants of the video frame queue manager.
`default_nettype none

package vfq_pkg;

  // Field widths.
  localparam int KIND_W     = 2;
  localparam int SIZE_W     = 24;
  localparam int TS_W       = 41;
  localparam int BYTES_W    = 32;
  localparam int BUF_W      = 16;
  localparam int SEG_W      = 22;
  localparam int RUN_W      = 16;
  localparam int STATUS_W   = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Request kinds.
  localparam logic [KIND_W-1:0] K_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] K_PULL  = 2'd1;
  localparam logic [KIND_W-1:0] K_EVENT = 2'd2;
  localparam logic [KIND_W-1:0] K_ERROR = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_PUSHED     = 4'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_DROP  = 4'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_ERR_FRAME  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_DROP_FRAME = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FIRST      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_INTERMED   = 4'd6;
  localparam logic [STATUS_W-1:0] ST_KEY_CONT   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_LAST       = 4'd8;
  localparam logic [STATUS_W-1:0] ST_EMPTY_END  = 4'd9;
  localparam logic [STATUS_W-1:0] ST_EVENT_OK   = 4'd10;
  localparam logic [STATUS_W-1:0] ST_EVENT_REJ  = 4'd11;
  localparam logic [STATUS_W-1:0] ST_ERROR_SET  = 4'd12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUF_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EVENT_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNBUF_MODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_MS = 3'd5;

  // Configuration reset values.
  localparam logic [BYTES_W-1:0] RST_MAX_BYTES  = 32'd16000000;
  localparam logic [BUF_W-1:0]   RST_BUF_TIME   = 16'd2000;
  localparam logic [SEG_W-1:0]   RST_SEGMENT_MS = 22'd60000;

  // One stored frame descriptor.
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [TS_W-1:0]   ts;
    logic              key;
  } desc_t;

endpackage

`default_nettype wire

// ===== sv/vfq_if.sv =====
// Valid/ready channel interfaces of the frame queue: requests, results, configuration.
`default_nettype none

interface vfq_in_if;
  import vfq_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SIZE_W-1:0] frame_size;
  logic [TS_W-1:0]   frame_ts_ms;
  logic              frame_is_key;
  logic              error_flag;

  modport source (output valid, kind, frame_size, frame_ts_ms, frame_is_key, error_flag,
                  input ready);
  modport sink (input valid, kind, frame_size, frame_ts_ms, frame_is_key, error_flag,
                output ready);
endinterface

interface vfq_out_if #(parameter int CNT_W = 9);
  import vfq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SIZE_W-1:0]   out_size;
  logic [TS_W-1:0]     out_ts_ms;
  logic                out_is_key;
  logic [BYTES_W-1:0]  queued_bytes;
  logic [CNT_W-1:0]    queued_count;
  logic [RUN_W-1:0]    drop_count;

  modport source (output valid, status, out_size, out_ts_ms, out_is_key, queued_bytes,
                  queued_count, drop_count, input ready);
  modport sink (input valid, status, out_size, out_ts_ms, out_is_key, queued_bytes,
                queued_count, drop_count, output ready);
endinterface

interface vfq_cfg_if;
  import vfq_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/video_frame_queue_manager.sv =====
// Top level of the video frame queue manager: control, accounting and result register.
//
// Channel    Dir   Handshake      Payload
// cfg_chan   in    valid/ready    index, data (register write)
// in_chan    in    valid/ready    kind, frame_size, frame_ts_ms, frame_is_key, error_flag
// out_chan   out   valid/ready    status, out_size, out_ts_ms, out_is_key, queued_bytes,
//                                 queued_count, drop_count
//
// A request is accepted in the idle state, which reads the head descriptor and its
// successor from the descriptor memory; the execute state works on the read data.
// An event in event mode adds a trim step per trimmed frame (one memory read each).
// One request is in flight at a time; the result register lets the next request in
// while a result waits. The execute state holds while the result register is full and
// not taken; trim steps do not wait. Reset is synchronous; the memory needs no
// clearing pass, configuration returns to its defaults.
`default_nettype none
`include "assert_macros.svh"

module video_frame_queue_manager #(
  parameter int QUEUE_DEPTH = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  vfq_cfg_if.sink   cfg_chan,
  vfq_in_if.sink    in_chan,
  vfq_out_if.source out_chan
);
  import vfq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = PTR_W + 2;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

  // Control states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic elapsed_ge(input logic [TS_W-1:0] from_ts,
                                      input logic [TS_W-1:0] to_ts,
                                      input logic [TS_W-1:0] span);
    return (to_ts >= from_ts) && ((to_ts - from_ts) >= span);
  endfunction

  // Configuration registers.
  logic [BYTES_W-1:0] max_bytes_r;
  logic [BUF_W-1:0]   buf_time_r;
  logic               event_mode_r;
  logic               unbuf_mode_r;
  logic               drop_en_r;
  logic [SEG_W-1:0]   segment_ms_r;

  // Queue and session state.
  logic             state_r, state_nxt;
  logic [PTR_W-1:0] head_ptr_r, head_ptr_nxt;
  logic [PTR_W-1:0] tail_ptr_r, tail_ptr_nxt;
  logic [CNT_W-1:0] entry_count_r, entry_count_nxt;
  logic [BYTES_W-1:0] byte_total_r, byte_total_nxt;
  logic [TS_W-1:0]  oldest_ts_r, oldest_ts_nxt;
  logic [TS_W-1:0]  newest_ts_r, newest_ts_nxt;
  logic [TS_W-1:0]  seg_start_r, seg_start_nxt;
  logic [RUN_W-1:0] drop_run_r, drop_run_nxt;
  logic             dropping_r, dropping_nxt;
  logic             seg_valid_r, seg_valid_nxt;
  logic             event_active_r, event_active_nxt;
  logic             error_state_r, error_state_nxt;
  logic             flowing_r, flowing_nxt;

  // Latched request.
  logic [KIND_W-1:0] kind_r;
  logic [SIZE_W-1:0] fsize_r;
  logic [TS_W-1:0]   fts_r;
  logic              fkey_r;
  logic              eflag_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic [TS_W-1:0]     out_ts_r;
  logic                out_key_r;
  logic [BYTES_W-1:0]  out_bytes_r;
  logic [CNT_W-1:0]    out_count_r;
  logic [RUN_W-1:0]    out_run_r;

  // Execute-cycle signals.
  logic [STATUS_W-1:0] res_status;
  logic [SIZE_W-1:0]   res_size;
  logic [TS_W-1:0]     res_ts;
  logic                res_key;
  logic                done;
  logic                trim_step;
  logic                pop_fire;
  logic                in_fire;
  logic                out_free;
  logic                mem_wr_en;
  logic                mem_rd_en;
  logic [PTR_W-1:0]    rd_addr_head;
  desc_t               wr_desc;
  desc_t               head_desc;
  desc_t               next_desc;

  // Shared pop arithmetic and flags.
  logic [PTR_W-1:0]   head_adv;
  logic [CNT_W-1:0]   cnt_dec;
  logic [BYTES_W-1:0] pop_bytes;
  logic [BYTES_W:0]   push_sum;
  logic [RUN_W-1:0]   run_bump;
  logic               window_hit;
  logic               trim_cond;

  // Pointer bookkeeping check value.
  logic [SUM_W-1:0] ptr_sum;
  logic [SUM_W-1:0] ptr_wrap;
  logic             ptr_ok;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign head_adv  = ptr_inc(head_ptr_r);
  assign cnt_dec   = entry_count_r - ONE_CNT;
  assign pop_bytes = (byte_total_r >= {8'd0, head_desc.size}) ?
                     byte_total_r - {8'd0, head_desc.size} : '0;
  assign push_sum  = {1'b0, byte_total_r} + {9'd0, fsize_r};
  assign run_bump  = (drop_run_r != '1) ? drop_run_r + RUN_W'(1) : drop_run_r;
  assign window_hit = elapsed_ge(oldest_ts_r, newest_ts_r, {25'd0, buf_time_r});
  assign trim_cond = (entry_count_r != '0) && (newest_ts_r >= oldest_ts_r) &&
                     ((newest_ts_r - oldest_ts_r) > {25'd0, buf_time_r});

  assign wr_desc = '{size: fsize_r, ts: fts_r, key: fkey_r};

  // Descriptor storage.
  vfq_desc_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (tail_ptr_r),
    .wr_data   (wr_desc),
    .rd_en     (mem_rd_en),
    .rd_addr_a (rd_addr_head),
    .rd_addr_b (ptr_inc(rd_addr_head)),
    .rd_data_a (head_desc),
    .rd_data_b (next_desc)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r  <= RST_MAX_BYTES;
      buf_time_r   <= RST_BUF_TIME;
      event_mode_r <= 1'b0;
      unbuf_mode_r <= 1'b0;
      drop_en_r    <= 1'b1;
      segment_ms_r <= RST_SEGMENT_MS;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      case (cfg_chan.index)
        REG_MAX_BYTES:  max_bytes_r  <= cfg_chan.data;
        REG_BUF_TIME:   buf_time_r   <= cfg_chan.data[BUF_W-1:0];
        REG_EVENT_MODE: event_mode_r <= cfg_chan.data[0];
        REG_UNBUF_MODE: unbuf_mode_r <= cfg_chan.data[0];
        REG_DROP_EN:    drop_en_r    <= cfg_chan.data[0];
        REG_SEGMENT_MS: segment_ms_r <= cfg_chan.data[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  // Request execution.
  always_comb begin
    state_nxt        = state_r;
    head_ptr_nxt     = head_ptr_r;
    tail_ptr_nxt     = tail_ptr_r;
    entry_count_nxt  = entry_count_r;
    byte_total_nxt   = byte_total_r;
    oldest_ts_nxt    = oldest_ts_r;
    newest_ts_nxt    = newest_ts_r;
    seg_start_nxt    = seg_start_r;
    drop_run_nxt     = drop_run_r;
    dropping_nxt     = dropping_r;
    seg_valid_nxt    = seg_valid_r;
    event_active_nxt = event_active_r;
    error_state_nxt  = error_state_r;
    flowing_nxt      = flowing_r;
    res_status       = ST_PUSHED;
    res_size         = '0;
    res_ts           = '0;
    res_key          = 1'b0;
    done             = 1'b0;
    trim_step        = 1'b0;
    pop_fire         = 1'b0;
    mem_wr_en        = 1'b0;
    mem_rd_en        = 1'b0;
    rd_addr_head     = head_ptr_r;

    case (state_r)
      S_IDLE: begin
        // Fetch the head descriptor and its successor for the new request.
        if (in_fire) begin
          mem_rd_en = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if ((kind_r == K_EVENT) && event_mode_r && trim_cond) begin
          // Trim one frame from the front and fetch the new head.
          trim_step        = 1'b1;
          pop_fire         = 1'b1;
          event_active_nxt = 1'b1;
          head_ptr_nxt     = head_adv;
          entry_count_nxt  = cnt_dec;
          byte_total_nxt   = pop_bytes;
          if (entry_count_r != ONE_CNT) begin
            oldest_ts_nxt = next_desc.ts;
          end
          mem_rd_en    = 1'b1;
          rd_addr_head = head_adv;
        end else if (out_free) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
          case (kind_r)
            K_PUSH: begin
              // Drop control, then append.
              res_status = ST_PUSHED;
              if (entry_count_r == FULL_CNT) begin
                res_status = ST_PUSH_DROP;
              end else if (drop_en_r) begin
                if (byte_total_r >= max_bytes_r) begin
                  if (!dropping_r) begin
                    drop_run_nxt = run_bump;
                  end
                  dropping_nxt = 1'b1;
                  res_status   = ST_PUSH_DROP;
                end else if (dropping_r) begin
                  if (!fkey_r) begin
                    drop_run_nxt = run_bump;
                    res_status   = ST_PUSH_DROP;
                  end else begin
                    drop_run_nxt = '0;
                    dropping_nxt = 1'b0;
                  end
                end
              end
              if (res_status == ST_PUSHED) begin
                mem_wr_en = 1'b1;
                if (entry_count_r == '0) begin
                  oldest_ts_nxt = fts_r;
                end
                tail_ptr_nxt    = ptr_inc(tail_ptr_r);
                entry_count_nxt = entry_count_r + ONE_CNT;
                byte_total_nxt  = push_sum[BYTES_W] ? '1 : push_sum[BYTES_W-1:0];
                newest_ts_nxt   = fts_r;
              end
            end

            K_PULL: begin
              if (entry_count_r == '0) begin
                res_status    = ST_EMPTY_END;
                seg_valid_nxt = 1'b0;
                flowing_nxt   = unbuf_mode_r ? 1'b0 : dropping_r;
              end else if (!unbuf_mode_r && !flowing_r && !(window_hit || dropping_r)) begin
                res_status = ST_NOT_READY;
              end else begin
                // Remove the front descriptor.
                if (!unbuf_mode_r) begin
                  flowing_nxt = 1'b1;
                end
                pop_fire        = 1'b1;
                head_ptr_nxt    = head_adv;
                entry_count_nxt = cnt_dec;
                byte_total_nxt  = pop_bytes;
                res_size        = head_desc.size;
                res_ts          = head_desc.ts;
                res_key         = head_desc.key;
                if (error_state_r && !head_desc.key) begin
                  res_status = ST_ERR_FRAME;
                end else begin
                  error_state_nxt = 1'b0;
                  if (event_mode_r) begin
                    flowing_nxt = 1'b0;
                  end
                  oldest_ts_nxt = (entry_count_r != ONE_CNT) ? next_desc.ts : head_desc.ts;
                  if (event_mode_r && !event_active_r) begin
                    res_status = ST_DROP_FRAME;
                  end else begin
                    // Segment labelling.
                    if (head_desc.key) begin
                      if (!seg_valid_r) begin
                        seg_start_nxt = head_desc.ts;
                        seg_valid_nxt = 1'b1;
                        res_status    = ST_FIRST;
                      end else if (!event_mode_r &&
                                   elapsed_ge(seg_start_r, head_desc.ts,
                                              {19'd0, segment_ms_r})) begin
                        seg_start_nxt = head_desc.ts;
                        res_status    = ST_FIRST;
                      end else begin
                        res_status = ST_KEY_CONT;
                      end
                    end else begin
                      res_status = ST_INTERMED;
                    end
                    // Event recording ends after twice the window.
                    if (event_mode_r && event_active_r && seg_valid_nxt &&
                        elapsed_ge(seg_start_nxt, head_desc.ts,
                                   {24'd0, buf_time_r, 1'b0})) begin
                      res_status       = ST_LAST;
                      event_active_nxt = 1'b0;
                      seg_valid_nxt    = 1'b0;
                    end
                  end
                end
              end
            end

            K_EVENT: begin
              if (event_mode_r) begin
                event_active_nxt = 1'b1;
                res_status       = ST_EVENT_OK;
              end else begin
                res_status = ST_EVENT_REJ;
              end
            end

            K_ERROR: begin
              error_state_nxt = eflag_r;
              if (!eflag_r) begin
                seg_valid_nxt = 1'b0;
              end
              res_status = ST_ERROR_SET;
            end

            default: ;
          endcase
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and accounting registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      head_ptr_r     <= '0;
      tail_ptr_r     <= '0;
      entry_count_r  <= '0;
      byte_total_r   <= '0;
      oldest_ts_r    <= '0;
      newest_ts_r    <= '0;
      seg_start_r    <= '0;
      drop_run_r     <= '0;
      dropping_r     <= 1'b0;
      seg_valid_r    <= 1'b0;
      event_active_r <= 1'b0;
      error_state_r  <= 1'b0;
      flowing_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      head_ptr_r     <= head_ptr_nxt;
      tail_ptr_r     <= tail_ptr_nxt;
      entry_count_r  <= entry_count_nxt;
      byte_total_r   <= byte_total_nxt;
      oldest_ts_r    <= oldest_ts_nxt;
      newest_ts_r    <= newest_ts_nxt;
      seg_start_r    <= seg_start_nxt;
      drop_run_r     <= drop_run_nxt;
      dropping_r     <= dropping_nxt;
      seg_valid_r    <= seg_valid_nxt;
      event_active_r <= event_active_nxt;
      error_state_r  <= error_state_nxt;
      flowing_r      <= flowing_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result valid: set on completion, cleared when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r  <= in_chan.kind;
      fsize_r <= in_chan.frame_size;
      fts_r   <= in_chan.frame_ts_ms;
      fkey_r  <= in_chan.frame_is_key;
      eflag_r <= in_chan.error_flag;
    end
    if (done) begin
      out_status_r <= res_status;
      out_size_r   <= res_size;
      out_ts_r     <= res_ts;
      out_key_r    <= res_key;
      out_bytes_r  <= byte_total_nxt;
      out_count_r  <= entry_count_nxt;
      out_run_r    <= drop_run_nxt;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.out_size     = out_size_r;
  assign out_chan.out_ts_ms    = out_ts_r;
  assign out_chan.out_is_key   = out_key_r;
  assign out_chan.queued_bytes = out_bytes_r;
  assign out_chan.queued_count = out_count_r;
  assign out_chan.drop_count   = out_run_r;

  // Tail must equal head plus count, modulo the depth.
  assign ptr_sum  = SUM_W'(head_ptr_r) + SUM_W'(entry_count_r);
  assign ptr_wrap = (ptr_sum >= DEPTH_SUM) ? ptr_sum - DEPTH_SUM : ptr_sum;
  assign ptr_ok   = (ptr_wrap == SUM_W'(tail_ptr_r));

  `VFQ_ASSERT_IMP(a_ptr_consistent, clk, rst_n, 1'b1, ptr_ok, "tail pointer out of step with head and count")
  `VFQ_ASSERT_IMP(a_write_not_full, clk, rst_n, mem_wr_en, entry_count_r != FULL_CNT, "descriptor written into a full queue")
  `VFQ_ASSERT_NXT(a_pop_count, clk, rst_n, pop_fire, entry_count_r == ($past(entry_count_r) - ONE_CNT), "pop did not remove exactly one entry")
  `VFQ_ASSERT_NXT(a_trim_continues, clk, rst_n, trim_step, state_r == S_EXEC, "trim step left the execute state")

endmodule

`default_nettype wire

// ===== sv/vfq_desc_mem.sv =====
// Descriptor memory: one write port and two registered read ports.
`default_nettype none

module vfq_desc_mem #(
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  vfq_pkg::desc_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output vfq_pkg::desc_t           rd_data_a,
  output vfq_pkg::desc_t           rd_data_b
);
  import vfq_pkg::*;

  desc_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports; the data registers hold while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire
